>>> rtl/stat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stat_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_W         = 4;

    localparam logic [3:0] OP_SAMPLE    = 4'd0;
    localparam logic [3:0] OP_SET_LIM   = 4'd1;
    localparam logic [3:0] OP_SET_TIME  = 4'd2;
    localparam logic [3:0] OP_ACK       = 4'd3;
    localparam logic [3:0] OP_ACK_ALL   = 4'd4;
    localparam logic [3:0] OP_RESET     = 4'd5;
    localparam logic [3:0] OP_RESET_ALL = 4'd6;
    localparam logic [3:0] OP_REMOVE    = 4'd7;
    localparam logic [3:0] OP_QUERY     = 4'd8;

    localparam logic [1:0] MODE_ABOVE   = 2'd0;
    localparam logic [1:0] MODE_BELOW   = 2'd1;
    localparam logic [1:0] MODE_BETWEEN = 2'd2;
    localparam logic [1:0] MODE_OUTSIDE = 2'd3;

    localparam logic [1:0] ST_INACTIVE = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_ACKED    = 2'd2;

    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [31:0] DEF_HOLDOFF_RST = 32'd5000;

    localparam logic CFG_HOLDOFF  = 1'b0;
    localparam logic CFG_DEBOUNCE = 1'b1;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [1:0]         mode;
        logic [31:0]        holdoff;
        logic [31:0]        debounce;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] fire_time;
        logic [15:0] count;
        logic [31:0] cond_start;
        logic        pending;
    } t_dyn;

    typedef struct packed {
        logic [3:0]         op;
        logic [CH_W-1:0]    ch;
        logic signed [31:0] sample;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [1:0]         mode;
        logic [31:0]        holdoff;
        logic [31:0]        debounce;
        logic [31:0]        now;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic        fired;
        logic [1:0]  state;
        logic [15:0] count;
        logic [31:0] fire_time;
    } t_res;

    function automatic t_dyn f_sweep(input logic [3:0] op, input t_dyn d);
        t_dyn r;
        r = d;
        if (op == OP_RESET_ALL) begin
            r = '0;
        end else if (d.state == ST_ACTIVE) begin
            r.state = ST_ACKED;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/stat_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module stat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/stat_eval.sv
`timescale 1ns / 1ps
`default_nettype none
module stat_eval (
    input  wire logic          i_valid,
    input  wire stat_pkg::t_req i_req,
    input  wire stat_pkg::t_cfg i_cfg,
    input  wire stat_pkg::t_dyn i_dyn,
    input  wire logic [31:0]   i_def_holdoff,
    input  wire logic [31:0]   i_def_debounce,
    output logic               o_cfg_we,
    output stat_pkg::t_cfg     o_cfg,
    output logic               o_dyn_we,
    output stat_pkg::t_dyn     o_dyn,
    output logic               o_valid,
    output stat_pkg::t_res     o_res
);
    logic        met;
    logic        hold_over;
    logic        deb_over;
    logic        can_fire;
    logic        fire_now;
    logic [31:0] since_fire;
    logic [31:0] since_start;

    always_comb begin
        unique case (i_cfg.mode)
            stat_pkg::MODE_ABOVE:   met = i_req.sample > i_cfg.hi;
            stat_pkg::MODE_BELOW:   met = i_req.sample < i_cfg.lo;
            stat_pkg::MODE_BETWEEN: met = (i_req.sample >= i_cfg.lo) &&
                                          (i_req.sample <= i_cfg.hi);
            default:                met = (i_req.sample < i_cfg.lo) ||
                                          (i_req.sample > i_cfg.hi);
        endcase
        since_fire  = i_req.now - i_dyn.fire_time;
        since_start = i_req.now - i_dyn.cond_start;
        hold_over   = (i_dyn.fire_time == '0) || (since_fire >= i_cfg.holdoff);
        deb_over    = since_start >= i_cfg.debounce;
        can_fire    = (i_dyn.state != stat_pkg::ST_ACTIVE) && hold_over;
    end

    always_comb begin
        o_cfg    = i_cfg;
        o_dyn    = i_dyn;
        o_cfg_we = 1'b0;
        o_dyn_we = 1'b0;
        o_valid  = i_valid;
        o_res    = '0;
        fire_now = 1'b0;

        unique case (i_req.op)
            stat_pkg::OP_SAMPLE: begin
                if (i_valid) begin
                    o_res.ok = 1'b1;
                    o_dyn_we = 1'b1;
                    if (i_cfg.debounce != '0) begin
                        if (met && !i_dyn.pending) begin
                            o_dyn.pending    = 1'b1;
                            o_dyn.cond_start = i_req.now;
                        end else if (met) begin
                            fire_now = deb_over && can_fire;
                        end else begin
                            o_dyn.pending = 1'b0;
                        end
                    end else begin
                        if (met && can_fire) begin
                            fire_now = 1'b1;
                        end else if (!met && i_dyn.state == stat_pkg::ST_ACTIVE) begin
                            o_dyn.state = stat_pkg::ST_INACTIVE;
                        end
                    end
                end
            end
            stat_pkg::OP_SET_LIM: begin
                if (!i_valid) begin
                    o_cfg.holdoff  = i_def_holdoff;
                    o_cfg.debounce = i_def_debounce;
                    o_dyn          = '0;
                end
                o_cfg.lo    = i_req.lo;
                o_cfg.hi    = i_req.hi;
                o_cfg.mode  = i_req.mode;
                o_dyn.state = stat_pkg::ST_INACTIVE;
                o_cfg_we    = 1'b1;
                o_dyn_we    = 1'b1;
                o_valid     = 1'b1;
                o_res.ok    = 1'b1;
            end
            stat_pkg::OP_SET_TIME: begin
                if (i_valid) begin
                    o_cfg.holdoff  = i_req.holdoff;
                    o_cfg.debounce = i_req.debounce;
                    o_cfg_we       = 1'b1;
                    o_res.ok       = 1'b1;
                end
            end
            stat_pkg::OP_ACK: begin
                if (i_valid) begin
                    if (i_dyn.state == stat_pkg::ST_ACTIVE) begin
                        o_dyn.state = stat_pkg::ST_ACKED;
                    end
                    o_dyn_we = 1'b1;
                    o_res.ok = 1'b1;
                end
            end
            stat_pkg::OP_ACK_ALL, stat_pkg::OP_RESET_ALL: begin
                o_res.ok = 1'b1;
            end
            stat_pkg::OP_RESET: begin
                if (i_valid) begin
                    o_dyn    = '0;
                    o_dyn_we = 1'b1;
                    o_res.ok = 1'b1;
                end
            end
            stat_pkg::OP_REMOVE: begin
                if (i_valid) begin
                    o_valid  = 1'b0;
                    o_res.ok = 1'b1;
                end
            end
            stat_pkg::OP_QUERY: begin
                o_res.ok = i_valid;
            end
            default: begin
                o_res.ok = 1'b0;
            end
        endcase

        if (fire_now) begin
            o_dyn.state     = stat_pkg::ST_ACTIVE;
            o_dyn.fire_time = i_req.now;
            if (i_dyn.count != stat_pkg::COUNT_MAX) begin
                o_dyn.count = i_dyn.count + 16'd1;
            end
        end

        o_res.fired = fire_now;
        if (o_valid) begin
            o_res.state     = o_dyn.state;
            o_res.count     = o_dyn.count;
            o_res.fire_time = o_dyn.fire_time;
        end
    end
endmodule
`default_nettype wire

>>> rtl/sensor_threshold_alarm_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Alarm table of 16 channels. A command is taken when start is high and busy
// is low; its single result appears on o_done in the cycle after the update
// state, high for exactly one cycle, and cannot be held off. Most commands read
// the channel entry from the synchronous memories, then update it and write it
// back. Acknowledge all and reset all walk the state memory, reading and then
// writing each channel, then read back the addressed channel. Configuration
// writes set the registered default holdoff and debounce times.
module sensor_threshold_alarm_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_op,
    input  wire logic [3:0]  i_channel,
    input  wire logic [31:0] i_sample,
    input  wire logic [31:0] i_low_limit,
    input  wire logic [31:0] i_high_limit,
    input  wire logic [1:0]  i_compare_mode,
    input  wire logic [31:0] i_holdoff_ms,
    input  wire logic [31:0] i_debounce_ms,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_done,
    output logic [3:0]       o_channel_out,
    output logic             o_done_ok,
    output logic             o_alert_fired,
    output logic [1:0]       o_alert_state,
    output logic [15:0]      o_fire_count_out,
    output logic [31:0]      o_fire_time
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SW_RD  = 3'd2;
    localparam logic [2:0] S_SW_WR  = 3'd3;
    localparam logic [2:0] S_FIN_RD = 3'd4;

    localparam int CFG_W = $bits(stat_pkg::t_cfg);
    localparam int DYN_W = $bits(stat_pkg::t_dyn);

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic [stat_pkg::CH_W-1:0]       r_idx;
    logic [stat_pkg::NUM_CHANNELS-1:0] r_valid;
    logic [31:0]                     r_def_holdoff;
    logic [31:0]                     r_def_debounce;
    stat_pkg::t_req                  r_req;
    logic                            accept;

    logic [stat_pkg::CH_W-1:0] rd_addr;
    logic [CFG_W-1:0]          cfg_rd_bits;
    logic [DYN_W-1:0]          dyn_rd_bits;
    stat_pkg::t_cfg            cfg_rd;
    stat_pkg::t_dyn            dyn_rd;

    logic                      ev_cfg_we;
    stat_pkg::t_cfg            ev_cfg;
    logic                      ev_dyn_we;
    stat_pkg::t_dyn            ev_dyn;
    logic                      ev_valid;
    stat_pkg::t_res            ev_res;

    logic                      dyn_we;
    logic [stat_pkg::CH_W-1:0] dyn_waddr;
    stat_pkg::t_dyn            dyn_wdata;
    logic                      is_sweep_op;

    assign accept      = start && !busy;
    assign busy        = r_state != S_IDLE;
    assign is_sweep_op = (i_op == stat_pkg::OP_ACK_ALL) || (i_op == stat_pkg::OP_RESET_ALL);
    assign cfg_rd      = stat_pkg::t_cfg'(cfg_rd_bits);
    assign dyn_rd      = stat_pkg::t_dyn'(dyn_rd_bits);

    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = i_channel;
            S_SW_RD: rd_addr = r_idx;
            default: rd_addr = r_req.ch;
        endcase
    end

    always_comb begin
        if (r_state == S_SW_WR) begin
            dyn_we    = r_valid[r_idx];
            dyn_waddr = r_idx;
            dyn_wdata = stat_pkg::f_sweep(r_req.op, dyn_rd);
        end else begin
            dyn_we    = (r_state == S_EXEC) && ev_dyn_we;
            dyn_waddr = r_req.ch;
            dyn_wdata = ev_dyn;
        end
    end

    stat_ram #(.WIDTH(CFG_W), .DEPTH(stat_pkg::NUM_CHANNELS)) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_EXEC) && ev_cfg_we),
        .i_waddr (r_req.ch),
        .i_wdata (ev_cfg),
        .i_raddr (rd_addr),
        .o_rdata (cfg_rd_bits)
    );

    stat_ram #(.WIDTH(DYN_W), .DEPTH(stat_pkg::NUM_CHANNELS)) u_dyn_ram (
        .i_clk   (i_clk),
        .i_we    (dyn_we),
        .i_waddr (dyn_waddr),
        .i_wdata (dyn_wdata),
        .i_raddr (rd_addr),
        .o_rdata (dyn_rd_bits)
    );

    stat_eval u_eval (
        .i_valid        (r_valid[r_req.ch]),
        .i_req          (r_req),
        .i_cfg          (cfg_rd),
        .i_dyn          (dyn_rd),
        .i_def_holdoff  (r_def_holdoff),
        .i_def_debounce (r_def_debounce),
        .o_cfg_we       (ev_cfg_we),
        .o_cfg          (ev_cfg),
        .o_dyn_we       (ev_dyn_we),
        .o_dyn          (ev_dyn),
        .o_valid        (ev_valid),
        .o_res          (ev_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = is_sweep_op ? S_SW_RD : S_EXEC;
                end
            end
            S_EXEC:   n_state = S_IDLE;
            S_SW_RD:  n_state = S_SW_WR;
            S_SW_WR: begin
                n_state = (r_idx == stat_pkg::CH_W'(stat_pkg::NUM_CHANNELS - 1)) ?
                          S_FIN_RD : S_SW_RD;
            end
            S_FIN_RD: n_state = S_EXEC;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_idx          <= '0;
            r_valid        <= '0;
            r_def_holdoff  <= stat_pkg::DEF_HOLDOFF_RST;
            r_def_debounce <= '0;
            o_done         <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= r_state == S_EXEC;
            if (accept) begin
                r_idx <= '0;
            end else if (r_state == S_SW_WR) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_EXEC) begin
                r_valid[r_req.ch] <= ev_valid;
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == stat_pkg::CFG_HOLDOFF) begin
                    r_def_holdoff <= i_cfg_data;
                end else begin
                    r_def_debounce <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op       <= i_op;
            r_req.ch       <= i_channel;
            r_req.sample   <= i_sample;
            r_req.lo       <= i_low_limit;
            r_req.hi       <= i_high_limit;
            r_req.mode     <= i_compare_mode;
            r_req.holdoff  <= i_holdoff_ms;
            r_req.debounce <= i_debounce_ms;
            r_req.now      <= i_now_ms;
        end
        if (r_state == S_EXEC) begin
            o_channel_out    <= r_req.ch;
            o_done_ok        <= ev_res.ok;
            o_alert_fired    <= ev_res.fired;
            o_alert_state    <= ev_res.state;
            o_fire_count_out <= ev_res.count;
            o_fire_time      <= ev_res.fire_time;
        end
    end

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without an update cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after transfer");

    a_sweep_no_exec_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_RD || r_state == S_SW_WR || r_state == S_FIN_RD) |-> !o_done)
        else $error("result strobe during sweep");
endmodule
`default_nettype wire

>>> tb/tb_sensor_threshold_alarm_table.sv
`timescale 1ns / 1ps
module tb_sensor_threshold_alarm_table;

    typedef struct {
        logic [3:0]  ch;
        logic        ok;
        logic        fired;
        logic [1:0]  state;
        logic [15:0] count;
        logic [31:0] ftime;
    } t_alarm_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_op;
    logic [3:0]  i_channel;
    logic [31:0] i_sample;
    logic [31:0] i_low_limit;
    logic [31:0] i_high_limit;
    logic [1:0]  i_compare_mode;
    logic [31:0] i_holdoff_ms;
    logic [31:0] i_debounce_ms;
    logic [31:0] i_now_ms;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        o_done;
    logic [3:0]  o_channel_out;
    logic        o_done_ok;
    logic        o_alert_fired;
    logic [1:0]  o_alert_state;
    logic [15:0] o_fire_count_out;
    logic [31:0] o_fire_time;

    sensor_threshold_alarm_table dut (.*);

    // predictor copy of the table
    logic [31:0]        dflt_hold;
    logic [31:0]        dflt_deb;
    logic               ch_valid  [stat_pkg::NUM_CHANNELS];
    logic signed [31:0] ch_lo     [stat_pkg::NUM_CHANNELS];
    logic signed [31:0] ch_hi     [stat_pkg::NUM_CHANNELS];
    logic [1:0]         ch_mode   [stat_pkg::NUM_CHANNELS];
    logic [31:0]        ch_hold   [stat_pkg::NUM_CHANNELS];
    logic [31:0]        ch_deb    [stat_pkg::NUM_CHANNELS];
    logic [1:0]         ch_state  [stat_pkg::NUM_CHANNELS];
    logic [31:0]        ch_ftime  [stat_pkg::NUM_CHANNELS];
    logic [15:0]        ch_count  [stat_pkg::NUM_CHANNELS];
    logic [31:0]        ch_cstart [stat_pkg::NUM_CHANNELS];
    logic               ch_pend   [stat_pkg::NUM_CHANNELS];

    t_alarm_result pending_results[$];
    int err_cnt;
    int n_items;
    int n_fired;
    int idle_pct;
    logic [31:0] clk_ms;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void clear_channel(input int c);
        ch_state[c]  = stat_pkg::ST_INACTIVE;
        ch_ftime[c]  = '0;
        ch_count[c]  = '0;
        ch_cstart[c] = '0;
        ch_pend[c]   = 1'b0;
    endfunction

    function automatic void fire_channel(input int c, input logic [31:0] now);
        ch_state[c] = stat_pkg::ST_ACTIVE;
        ch_ftime[c] = now;
        if (ch_count[c] != stat_pkg::COUNT_MAX) ch_count[c] = ch_count[c] + 16'd1;
    endfunction

    function automatic logic may_fire(input int c, input logic [31:0] now);
        logic [31:0] held;
        held = now - ch_ftime[c];
        return ch_state[c] != stat_pkg::ST_ACTIVE &&
               (ch_ftime[c] == 0 || held >= ch_hold[c]);
    endfunction

    function automatic t_alarm_result predict_alarm_result(
        input logic [3:0] op, input logic [3:0] ch, input logic signed [31:0] smp,
        input logic [31:0] lo, input logic [31:0] hi, input logic [1:0] mode,
        input logic [31:0] hold, input logic [31:0] deb, input logic [31:0] now);
        t_alarm_result r;
        logic met;
        logic [31:0] waited;
        int c;
        c = ch;
        r = '{ch, 1'b0, 1'b0, stat_pkg::ST_INACTIVE, 16'd0, 32'd0};
        case (op)
            stat_pkg::OP_SAMPLE: begin
                if (ch_valid[c]) begin
                    r.ok = 1'b1;
                    case (ch_mode[c])
                        stat_pkg::MODE_ABOVE:   met = smp > ch_hi[c];
                        stat_pkg::MODE_BELOW:   met = smp < ch_lo[c];
                        stat_pkg::MODE_BETWEEN: met = smp >= ch_lo[c] && smp <= ch_hi[c];
                        default:                met = smp < ch_lo[c] || smp > ch_hi[c];
                    endcase
                    if (ch_deb[c] != 0) begin
                        if (met && !ch_pend[c]) begin
                            ch_pend[c]   = 1'b1;
                            ch_cstart[c] = now;
                        end else if (met) begin
                            waited = now - ch_cstart[c];
                            if (waited >= ch_deb[c] && may_fire(c, now)) begin
                                fire_channel(c, now);
                                r.fired = 1'b1;
                            end
                        end else begin
                            ch_pend[c] = 1'b0;
                        end
                    end else if (met && may_fire(c, now)) begin
                        fire_channel(c, now);
                        r.fired = 1'b1;
                    end else if (!met && ch_state[c] == stat_pkg::ST_ACTIVE) begin
                        ch_state[c] = stat_pkg::ST_INACTIVE;
                    end
                end
            end
            stat_pkg::OP_SET_LIM: begin
                if (!ch_valid[c]) begin
                    ch_valid[c] = 1'b1;
                    ch_hold[c]  = dflt_hold;
                    ch_deb[c]   = dflt_deb;
                    clear_channel(c);
                end
                ch_lo[c]    = lo;
                ch_hi[c]    = hi;
                ch_mode[c]  = mode;
                ch_state[c] = stat_pkg::ST_INACTIVE;
                r.ok = 1'b1;
            end
            stat_pkg::OP_SET_TIME: begin
                if (ch_valid[c]) begin
                    ch_hold[c] = hold;
                    ch_deb[c]  = deb;
                    r.ok = 1'b1;
                end
            end
            stat_pkg::OP_ACK: begin
                if (ch_valid[c]) begin
                    if (ch_state[c] == stat_pkg::ST_ACTIVE) ch_state[c] = stat_pkg::ST_ACKED;
                    r.ok = 1'b1;
                end
            end
            stat_pkg::OP_ACK_ALL: begin
                for (int i = 0; i < stat_pkg::NUM_CHANNELS; i++)
                    if (ch_valid[i] && ch_state[i] == stat_pkg::ST_ACTIVE)
                        ch_state[i] = stat_pkg::ST_ACKED;
                r.ok = 1'b1;
            end
            stat_pkg::OP_RESET: begin
                if (ch_valid[c]) begin
                    clear_channel(c);
                    r.ok = 1'b1;
                end
            end
            stat_pkg::OP_RESET_ALL: begin
                for (int i = 0; i < stat_pkg::NUM_CHANNELS; i++)
                    if (ch_valid[i]) clear_channel(i);
                r.ok = 1'b1;
            end
            stat_pkg::OP_REMOVE: begin
                if (ch_valid[c]) begin
                    ch_valid[c] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            stat_pkg::OP_QUERY: r.ok = ch_valid[c];
            default: ;
        endcase
        if (ch_valid[c]) begin
            r.state = ch_state[c];
            r.count = ch_count[c];
            r.ftime = ch_ftime[c];
        end
        return r;
    endfunction

    task automatic send_cmd(input logic [3:0] op, input logic [3:0] ch,
                            input logic [31:0] smp, input logic [31:0] lo,
                            input logic [31:0] hi, input logic [1:0] mode,
                            input logic [31:0] hold, input logic [31:0] deb,
                            input logic [31:0] now);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op           = op;
        i_channel      = ch;
        i_sample       = smp;
        i_low_limit    = lo;
        i_high_limit   = hi;
        i_compare_mode = mode;
        i_holdoff_ms   = hold;
        i_debounce_ms  = deb;
        i_now_ms       = now;
        start          = 1'b1;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(
            predict_alarm_result(op, ch, smp, lo, hi, mode, hold, deb, now));
        n_items++;
    endtask

    // shorthands for the common command shapes
    task automatic send_op(input logic [3:0] op, input logic [3:0] ch,
                           input logic [31:0] now);
        send_cmd(op, ch, $urandom, $urandom, $urandom, 2'($urandom), $urandom, $urandom,
                 now);
    endtask

    task automatic send_limits(input logic [3:0] ch, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [1:0] mode);
        send_cmd(stat_pkg::OP_SET_LIM, ch, $urandom, lo, hi, mode, $urandom, $urandom,
                 $urandom);
    endtask

    task automatic send_timing(input logic [3:0] ch, input logic [31:0] hold,
                               input logic [31:0] deb);
        send_cmd(stat_pkg::OP_SET_TIME, ch, $urandom, $urandom, $urandom, 2'($urandom),
                 hold, deb, $urandom);
    endtask

    task automatic send_sample(input logic [3:0] ch, input logic [31:0] smp,
                               input logic [31:0] now);
        send_cmd(stat_pkg::OP_SAMPLE, ch, smp, $urandom, $urandom, 2'($urandom),
                 $urandom, $urandom, now);
    endtask

    task automatic drain;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic addr, input logic [31:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (addr == stat_pkg::CFG_HOLDOFF) dflt_hold = data;
        else dflt_deb = data;
    endtask

    always @(posedge i_clk) begin
        t_alarm_result e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding, channel %0d", o_channel_out);
                err_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (e.fired) n_fired++;
                if (o_channel_out !== e.ch) begin
                    $error("channel_out exp %0h got %0h", e.ch, o_channel_out);
                    err_cnt++;
                end
                if (o_done_ok !== e.ok) begin
                    $error("done_ok exp %0h got %0h", e.ok, o_done_ok);
                    err_cnt++;
                end
                if (o_alert_fired !== e.fired) begin
                    $error("alert_fired exp %0h got %0h", e.fired, o_alert_fired);
                    err_cnt++;
                end
                if (o_alert_state !== e.state) begin
                    $error("alert_state exp %0h got %0h", e.state, o_alert_state);
                    err_cnt++;
                end
                if (o_fire_count_out !== e.count) begin
                    $error("fire_count_out exp %0h got %0h", e.count, o_fire_count_out);
                    err_cnt++;
                end
                if (o_fire_time !== e.ftime) begin
                    $error("fire_time exp %0h got %0h", e.ftime, o_fire_time);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_basic_ops;
        logic [3:0] op;
        write_cfg(stat_pkg::CFG_HOLDOFF, stat_pkg::DEF_HOLDOFF_RST);
        write_cfg(stat_pkg::CFG_DEBOUNCE, 32'd0);
        for (int k = 0; k < 8; k++) begin
            op = 4'(k);
            if (op != stat_pkg::OP_SET_LIM) send_op(op, 4'd0, 32'd7);
        end
        send_limits(4'd0, 32'h8000_0000, 32'h0001_0000, stat_pkg::MODE_ABOVE);
        send_sample(4'd0, 32'h7FFF_FFFF, 32'd0);
        send_sample(4'd0, 32'h8000_0000, 32'd0);
        send_sample(4'd0, 32'h7FFF_FFFF, 32'd1);
        send_op(stat_pkg::OP_ACK, 4'd0, 32'd2);
        send_sample(4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_limits(4'd15, 32'h8000_0000, 32'h7FFF_FFFF, stat_pkg::MODE_BELOW);
        send_sample(4'd15, 32'h8000_0000, 32'd3);
        send_limits(4'd2, 32'hFFFF_FFFF, 32'd1, stat_pkg::MODE_BETWEEN);
        send_sample(4'd2, 32'd0, 32'd4);
        send_limits(4'd3, 32'hFFFF_FFFF, 32'd1, stat_pkg::MODE_OUTSIDE);
        send_sample(4'd3, 32'd2, 32'd5);
        send_limits(4'd0, 32'd0, 32'd0, stat_pkg::MODE_ABOVE);
        send_op(stat_pkg::OP_ACK_ALL, 4'd1, 32'd6);
        send_op(stat_pkg::OP_RESET, 4'd2, 32'd7);
        send_op(stat_pkg::OP_RESET_ALL, 4'd15, 32'd8);
        send_op(stat_pkg::OP_REMOVE, 4'd3, 32'd9);
        send_op(stat_pkg::OP_QUERY, 4'd3, 32'd9);
        send_op(stat_pkg::OP_QUERY, 4'd15, 32'd9);
        send_op(4'd9, 4'd0, 32'd9);
        send_op(4'd15, 4'd15, 32'd9);
    endtask

    task automatic test_debounce;
        send_timing(4'd2, 32'd0, 32'd10);
        send_sample(4'd2, 32'd0, 32'd100);
        send_sample(4'd2, 32'd0, 32'd105);
        send_sample(4'd2, 32'd0, 32'd110);
        send_sample(4'd2, 32'd9, 32'd111);
        send_sample(4'd2, 32'd0, 32'd200);
    endtask

    task automatic test_clock_wrap;
        send_timing(4'd15, 32'd10, 32'd0);
        send_sample(4'd15, 32'h8000_0000, 32'hFFFF_FFFA);
        send_sample(4'd15, 32'd0, 32'hFFFF_FFFB);
        send_sample(4'd15, 32'h8000_0000, 32'd2);
        send_sample(4'd15, 32'd0, 32'd3);
        send_sample(4'd15, 32'h8000_0000, 32'd4);
    endtask

    task automatic random_item;
        logic [3:0] ch;
        logic [31:0] lo;
        logic [31:0] smp;
        int pick;
        ch = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if ($urandom_range(49) == 0) clk_ms = $urandom;
        else clk_ms = clk_ms + $urandom_range(0, 12);
        if (pick < 55) begin
            case ($urandom_range(7))
                0: smp = ch_lo[ch] - 1;
                1: smp = ch_lo[ch];
                2: smp = ch_hi[ch];
                3: smp = ch_hi[ch] + 1;
                4: smp = ch_lo[ch] + $urandom_range(0, 3);
                5: smp = ch_hi[ch] - $urandom_range(0, 3);
                default: smp = $urandom;
            endcase
            if (!ch_valid[ch]) smp = $urandom;
            send_sample(ch, smp, clk_ms);
        end else if (pick < 66) begin
            if ($urandom_range(4) == 0) send_limits(ch, $urandom, $urandom, 2'($urandom));
            else begin
                lo = $urandom_range(0, 32'h60000) - 32'h30000;
                send_limits(ch, lo, lo + $urandom_range(0, 32'h20000), 2'($urandom));
            end
        end else if (pick < 74) begin
            if ($urandom_range(5) == 0) send_timing(ch, $urandom, $urandom);
            else send_timing(ch, $urandom_range(0, 40),
                             ($urandom_range(1) == 0) ? 32'd0 : $urandom_range(1, 30));
        end else if (pick < 80) send_op(stat_pkg::OP_ACK, ch, clk_ms);
        else if (pick < 83) send_op(stat_pkg::OP_ACK_ALL, ch, clk_ms);
        else if (pick < 87) send_op(stat_pkg::OP_RESET, ch, clk_ms);
        else if (pick < 89) send_op(stat_pkg::OP_RESET_ALL, ch, clk_ms);
        else if (pick < 92) send_op(stat_pkg::OP_REMOVE, ch, clk_ms);
        else if (pick < 96) send_op(stat_pkg::OP_QUERY, ch, clk_ms);
        else send_op(4'($urandom_range(9, 15)), ch, clk_ms);
    endtask

    task automatic test_random_traffic;
        logic [31:0] holds [4];
        logic [31:0] debs  [4];
        holds = '{32'd0, 32'hFFFF_FFFF, 32'd5000, 32'd0};
        debs  = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0};
        holds[3] = $urandom_range(1, 30);
        debs[3]  = $urandom_range(1, 20);
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(stat_pkg::CFG_HOLDOFF, holds[ph % 4]);
            write_cfg(stat_pkg::CFG_DEBOUNCE, debs[ph % 4]);
            idle_pct = (ph < 2) ? 14 : (ph < 4) ? 52 : 0;
            repeat (325) random_item();
        end
    endtask

    initial begin
        err_cnt  = 0;
        n_items  = 0;
        n_fired  = 0;
        idle_pct = 14;
        clk_ms   = 32'd1000;
        dflt_hold = stat_pkg::DEF_HOLDOFF_RST;
        dflt_deb  = 32'd0;
        for (int i = 0; i < stat_pkg::NUM_CHANNELS; i++) begin
            ch_valid[i] = 1'b0;
            ch_lo[i]    = '0;
            ch_hi[i]    = '0;
            ch_mode[i]  = stat_pkg::MODE_ABOVE;
            ch_hold[i]  = '0;
            ch_deb[i]   = '0;
            clear_channel(i);
        end
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_op           = stat_pkg::OP_QUERY;
        i_channel      = '0;
        i_sample       = '0;
        i_low_limit    = '0;
        i_high_limit   = '0;
        i_compare_mode = stat_pkg::MODE_ABOVE;
        i_holdoff_ms   = '0;
        i_debounce_ms  = '0;
        i_now_ms       = '0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = stat_pkg::CFG_HOLDOFF;
        i_cfg_data     = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ops();
        test_debounce();
        test_clock_wrap();
        test_random_traffic();
        drain();

        $display("covered %0d commands with %0d alarm firings", n_items, n_fired);
        $display("all ops, debounce, holdoff, clock wrap, default timing sweeps");
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/stat_pkg.sv
rtl/stat_ram.sv
rtl/stat_eval.sv
rtl/sensor_threshold_alarm_table.sv
tb/tb_sensor_threshold_alarm_table.sv
